// ===== rtl/ect_pkg.sv =====
package ect_pkg;

    localparam int NUM_COUNTERS = 16;
    localparam int IDX_BITS     = $clog2(NUM_COUNTERS);
    localparam int CID_BITS     = 4;
    localparam int THREAD_BITS  = 8;
    localparam int COUNT_BITS   = 16;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 3;
    localparam int S_DATA_BITS  = 16;
    localparam int M_DATA_BITS  = 16;

    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [THREAD_BITS-1:0]        tid_t;
    typedef logic signed [COUNT_BITS-1:0]  count_t;

    localparam count_t CNT_MAX     = count_t'({1'b0, {(COUNT_BITS-1){1'b1}}});
    localparam count_t CNT_MIN     = count_t'({1'b1, {(COUNT_BITS-1){1'b0}}});
    localparam count_t CNT_ZERO    = count_t'(0);
    localparam count_t CNT_ONE     = count_t'(1);
    localparam count_t CNT_NEG_ONE = count_t'({COUNT_BITS{1'b1}});

    typedef enum logic [OP_BITS-1:0] {
        OP_CREATE     = 3'd0,
        OP_DESTROY    = 3'd1,
        OP_WAIT       = 3'd2,
        OP_WAIT_CLEAR = 3'd3,
        OP_SIGNAL     = 3'd4,
        OP_INTERRUPT  = 3'd5
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK        = 3'd0,
        STS_BLOCKED   = 3'd1,
        STS_INVALID   = 3'd2,
        STS_WAITER    = 3'd3,
        STS_NO_SLOT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RUN,
        FSM_RESP
    } fsm_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic advance;
        logic publish;
    } ect_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_op;
        logic create_hit;
        logic last_idx;
        logic out_full;
    } ect_sts_t;

endpackage

// ===== rtl/ect_ctrl.sv =====
module ect_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  ect_pkg::ect_sts_t sts,
    output ect_pkg::ect_cmd_t cmd
);

    ect_pkg::fsm_t state_reg;
    ect_pkg::fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ect_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ect_pkg::FSM_IDLE: begin
                if (s_tvalid) state_next = ect_pkg::FSM_RUN;
            end
            ect_pkg::FSM_RUN: begin
                if (!sts.scan_op || sts.create_hit || sts.last_idx) begin
                    state_next = ect_pkg::FSM_RESP;
                end
            end
            ect_pkg::FSM_RESP: begin
                if (!sts.out_full || m_tready) state_next = ect_pkg::FSM_IDLE;
            end
            default: state_next = ect_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ect_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ect_pkg::FSM_RUN: begin
                cmd.step    = 1'b1;
                cmd.advance = sts.scan_op && !sts.create_hit && !sts.last_idx;
            end
            ect_pkg::FSM_RESP: begin
                cmd.publish = !sts.out_full || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ect_pkg::FSM_RUN)
        else $error("accepted beat did not start execution");

    a_publish_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!sts.out_full || m_tready))
        else $error("result overwrote an untaken beat");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ect_pkg::FSM_RUN && sts.last_idx |=> state_reg != ect_pkg::FSM_RUN)
        else $error("scan ran past the last entry");

endmodule

// ===== rtl/ect_datapath.sv =====
module ect_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [ect_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  logic                               m_tready,
    input  ect_pkg::ect_cmd_t                  cmd,
    output ect_pkg::ect_sts_t                  sts,
    output logic                               m_tvalid,
    output logic [ect_pkg::M_DATA_BITS-1:0]    m_tdata
);

    // counter table
    logic               valid_reg [ect_pkg::NUM_COUNTERS];
    ect_pkg::count_t    cnt_reg   [ect_pkg::NUM_COUNTERS];
    ect_pkg::tid_t      waiter_reg[ect_pkg::NUM_COUNTERS];

    logic [ect_pkg::OP_BITS-1:0] op_reg;
    ect_pkg::tid_t               thr_reg;
    logic                        in_range_reg;
    ect_pkg::idx_t               idx_reg;

    ect_pkg::status_t            res_status_reg, res_status_next;
    ect_pkg::idx_t               res_id_reg,     res_id_next;
    ect_pkg::tid_t               res_wake_reg,   res_wake_next;
    logic                        res_was_reg,    res_was_next;

    logic                              m_tvalid_reg;
    logic [ect_pkg::M_DATA_BITS-1:0]   m_tdata_reg;

    logic [ect_pkg::OP_BITS-1:0]  in_op;
    logic [ect_pkg::CID_BITS-1:0] in_cid;
    ect_pkg::tid_t                in_thr;

    logic             rd_valid;
    ect_pkg::count_t  rd_cnt;
    ect_pkg::tid_t    rd_waiter;
    ect_pkg::count_t  cnt_inc;
    ect_pkg::count_t  cnt_dec;
    logic             cnt_pos;
    logic             ok;

    logic             wr_en;
    logic             wr_valid;
    ect_pkg::count_t  wr_cnt;
    ect_pkg::tid_t    wr_waiter;

    assign in_op  = s_tdata[2:0];
    assign in_cid = s_tdata[6:3];
    assign in_thr = s_tdata[14:7];

    assign rd_valid  = valid_reg[idx_reg];
    assign rd_cnt    = cnt_reg[idx_reg];
    assign rd_waiter = waiter_reg[idx_reg];

    // saturate at both ends
    assign cnt_inc = (rd_cnt == ect_pkg::CNT_MAX) ? rd_cnt : rd_cnt + ect_pkg::CNT_ONE;
    assign cnt_dec = (rd_cnt == ect_pkg::CNT_MIN) ? rd_cnt : rd_cnt - ect_pkg::CNT_ONE;
    assign cnt_pos = !rd_cnt[ect_pkg::COUNT_BITS-1] && (rd_cnt != ect_pkg::CNT_ZERO);
    assign ok      = rd_valid && in_range_reg;

    assign sts.scan_op    = (op_reg == ect_pkg::OP_CREATE) || (op_reg == ect_pkg::OP_INTERRUPT);
    assign sts.create_hit = (op_reg == ect_pkg::OP_CREATE) && !rd_valid;
    assign sts.last_idx   = idx_reg == ect_pkg::idx_t'(ect_pkg::NUM_COUNTERS - 1);
    assign sts.out_full   = m_tvalid_reg;

    always_comb begin
        wr_en           = 1'b0;
        wr_valid        = rd_valid;
        wr_cnt          = rd_cnt;
        wr_waiter       = rd_waiter;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_wake_next   = res_wake_reg;
        res_was_next    = res_was_reg;
        if (cmd.step) begin
            case (op_reg)
                ect_pkg::OP_CREATE: begin
                    if (!rd_valid) begin
                        wr_en           = 1'b1;
                        wr_valid        = 1'b1;
                        wr_cnt          = ect_pkg::CNT_ZERO;
                        wr_waiter       = '0;
                        res_status_next = ect_pkg::STS_OK;
                        res_id_next     = idx_reg;
                    end
                end
                ect_pkg::OP_DESTROY, ect_pkg::OP_SIGNAL: begin
                    if (!ok) begin
                        res_status_next = ect_pkg::STS_INVALID;
                    end else begin
                        wr_en         = 1'b1;
                        wr_valid      = (op_reg == ect_pkg::OP_SIGNAL);
                        wr_cnt        = cnt_inc;
                        wr_waiter     = '0;
                        res_wake_next = rd_waiter;
                    end
                end
                ect_pkg::OP_WAIT: begin
                    if (!ok) begin
                        res_status_next = ect_pkg::STS_INVALID;
                    end else if (cnt_pos) begin
                        wr_en  = 1'b1;
                        wr_cnt = cnt_dec;
                    end else if (rd_waiter == '0) begin
                        wr_en           = 1'b1;
                        wr_cnt          = cnt_dec;
                        wr_waiter       = thr_reg;
                        res_status_next = ect_pkg::STS_BLOCKED;
                    end else begin
                        res_status_next = ect_pkg::STS_WAITER;
                    end
                end
                ect_pkg::OP_WAIT_CLEAR: begin
                    if (!ok) begin
                        res_status_next = ect_pkg::STS_INVALID;
                    end else if (rd_waiter == '0) begin
                        wr_en           = 1'b1;
                        wr_cnt          = ect_pkg::CNT_NEG_ONE;
                        wr_waiter       = thr_reg;
                        res_status_next = ect_pkg::STS_BLOCKED;
                    end else begin
                        res_status_next = ect_pkg::STS_WAITER;
                    end
                end
                ect_pkg::OP_INTERRUPT: begin
                    // thread zero never matches an empty waiter slot
                    if (thr_reg != '0 && rd_valid && rd_waiter == thr_reg) begin
                        wr_en        = 1'b1;
                        wr_cnt       = cnt_inc;
                        wr_waiter    = '0;
                        res_was_next = 1'b1;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ect_pkg::NUM_COUNTERS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            valid_reg[idx_reg] <= wr_valid;
        end
    end

    // count and waiter are cleared by create before any use
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_reg[idx_reg]    <= wr_cnt;
            waiter_reg[idx_reg] <= wr_waiter;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= in_op;
            thr_reg        <= in_thr;
            in_range_reg   <= 32'(in_cid) < ect_pkg::NUM_COUNTERS;
            res_status_reg <= (in_op == ect_pkg::OP_CREATE) ? ect_pkg::STS_NO_SLOT
                                                            : ect_pkg::STS_OK;
            res_id_reg     <= '0;
            res_wake_reg   <= '0;
            res_was_reg    <= 1'b0;
            if (in_op == ect_pkg::OP_CREATE || in_op == ect_pkg::OP_INTERRUPT) begin
                idx_reg <= '0;
            end else begin
                idx_reg <= ect_pkg::idx_t'(in_cid);
            end
        end else begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_wake_reg   <= res_wake_next;
            res_was_reg    <= res_was_next;
            if (cmd.advance) idx_reg <= idx_reg + ect_pkg::idx_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_tdata_reg <= {res_was_reg, res_wake_reg,
                            ect_pkg::CID_BITS'(res_id_reg), res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_tvalid_reg)
        else $error("published result not presented");

endmodule

// ===== rtl/event_counter_table_core.sv =====
// Table of 16 event counters, each with a valid flag, a saturating signed
// 16-bit count and one waiting thread id. One operation per input beat, one
// result beat per operation. Destroy, wait, wait_clear, signal and unused
// opcodes touch only the addressed entry before the result is formed; create
// and interrupt walk the table through its single read/write port, one entry
// per cycle. Create stops at the first free slot or the last entry, and
// interrupt always walks every entry. A new operation is accepted once the
// previous result is in the output register, even if it has not been taken.
module event_counter_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], counter_id[6:3], thread_id[14:7], zero[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], new_id[6:3], wake_thread[14:7],
                                   // was_waiting[15]
);

    ect_pkg::ect_cmd_t cmd;
    ect_pkg::ect_sts_t sts;

    ect_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ect_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
